[hdl/dbq_pkg.sv]
// Shared constants and request/status codes for the bounded double-ended queue.
package dbq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned REQ_W = 3;
  localparam int unsigned ST_W  = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_COUNT      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_LIST       = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd3;

endpackage

[hdl/bounded_double_ended_queue_top.sv]
// Bounded double-ended queue over a ring store in a single synchronous memory.
// Results are registered: the first result appears in the cycle after its request is accepted.
// Push, pop, count and invalid requests: one item per cycle while busy_o is low, busy_o stays low.
// List: one result per stored entry on consecutive cycles, one memory read each;
// busy_o is high while the entries after the first are read. The receiver cannot stall results.
// Reset: indices and count clear at once; store contents stay undefined, no sweep.
module bounded_double_ended_queue_top
  import dbq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [REQ_W-1:0]                 req_type_i,
  input  logic [DATA_WIDTH-1:0]            entry_data_i,
  output logic                             valid_o,
  output logic [ST_W-1:0]                  status_o,
  output logic [DATA_WIDTH-1:0]            out_data_o,
  output logic [$clog2(DEPTH+1)-1:0]       entry_total_o,
  output logic                             last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(DEPTH - 1)) ? '0 : s + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] s);
    return (s == '0) ? IDX_W'(DEPTH - 1) : s - IDX_W'(1);
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic                  state_q, state_d;
  logic [IDX_W-1:0]      front_q, front_d;
  logic [IDX_W-1:0]      back_q, back_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      list_ptr_q, list_ptr_d;
  logic [CNT_W-1:0]      list_left_q, list_left_d;
  logic                  valid_q, valid_d;
  logic                  sel_q, sel_d;
  logic [ST_W-1:0]       status_q, status_d;
  logic                  last_q, last_d;

  logic                  we, re;
  logic [IDX_W-1:0]      waddr, raddr;
  logic                  accept, full, empty;

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    back_d      = back_q;
    count_d     = count_q;
    list_ptr_d  = list_ptr_q;
    list_left_d = list_left_q;
    valid_d     = 1'b0;
    sel_d       = 1'b0;
    status_d    = ST_OK;
    last_d      = 1'b1;
    we          = 1'b0;
    waddr       = back_q;
    re          = 1'b0;
    raddr       = front_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          case (req_type_i)
            REQ_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = back_q;
                back_d  = idx_inc(back_q);
                count_d = count_q + CNT_W'(1);
              end
            end
            REQ_PUSH_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = idx_dec(front_q);
                front_d = idx_dec(front_q);
                count_d = count_q + CNT_W'(1);
              end
            end
            REQ_POP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = idx_dec(back_q);
                back_d  = idx_dec(back_q);
                count_d = count_q - CNT_W'(1);
                sel_d   = 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                re      = 1'b1;
                raddr   = front_q;
                front_d = idx_inc(front_q);
                count_d = count_q - CNT_W'(1);
                sel_d   = 1'b1;
              end
            end
            REQ_COUNT: begin
              status_d = ST_OK;
            end
            REQ_LIST: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                // read the front entry now, walk the rest one read a cycle
                re          = 1'b1;
                raddr       = front_q;
                sel_d       = 1'b1;
                list_ptr_d  = idx_inc(front_q);
                list_left_d = count_q - CNT_W'(1);
                last_d      = (count_q == CNT_W'(1));
                if (count_q != CNT_W'(1)) begin
                  state_d = S_LIST;
                end
              end
            end
            default: begin
              status_d = ST_INVALID;
            end
          endcase
        end
      end
      S_LIST: begin
        re          = 1'b1;
        raddr       = list_ptr_q;
        sel_d       = 1'b1;
        valid_d     = 1'b1;
        list_ptr_d  = idx_inc(list_ptr_q);
        list_left_d = list_left_q - CNT_W'(1);
        last_d      = (list_left_q == CNT_W'(1));
        if (list_left_q == CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= entry_data_i;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      list_ptr_q  <= '0;
      list_left_q <= '0;
      valid_q     <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      list_ptr_q  <= list_ptr_d;
      list_left_q <= list_left_d;
      valid_q     <= valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign busy_o        = (state_q == S_LIST);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign out_data_o    = sel_q ? rdata_q : '0;
  assign entry_total_o = count_q;
  assign last_o        = last_q;

endmodule
